>>> design/swmk_pkg.sv
// swmk_pkg: shared types, constants and helpers for the swerve kinematics block
// used by swmk_cordic, swmk_sqrt and swerve_module_kinematics_top
`timescale 1ns / 1ps
package swmk_pkg;

	localparam int MODULES = 4;
	localparam int IDLE_W = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int SQRT_STEPS = 25;

	localparam logic signed [17:0] ANG_PI = 18'sd12868;
	localparam logic signed [17:0] ANG_HALF_PI = 18'sd6434;
	localparam logic signed [17:0] ANG_QUARTER_PI = 18'sd3217;
	localparam logic signed [17:0] ANG_TWO_PI = 18'sd25736;
	localparam logic signed [19:0] CORDIC_HALF_PI = 20'sd102944;
	localparam logic [17:0] SPEED_MAX = 18'd131071;

	typedef enum logic [2:0] {
		CFG_MODE  = 3'd0,
		CFG_DELAY = 3'd1,
		CFG_THR   = 3'd2,
		CFG_ROT   = 3'd3,
		CFG_IWR   = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROT,
		ST_SQX,
		ST_SQY,
		ST_START,
		ST_WAIT,
		ST_MUL,
		ST_FIN,
		ST_OUT
	} state_t;

	function automatic logic [16:0] atan_lut(input logic [3:0] i);
		logic [16:0] v;
		case (i)
			4'd0: v = 17'd51472;
			4'd1: v = 17'd30386;
			4'd2: v = 17'd16055;
			4'd3: v = 17'd8150;
			4'd4: v = 17'd4091;
			4'd5: v = 17'd2047;
			4'd6: v = 17'd1024;
			4'd7: v = 17'd512;
			4'd8: v = 17'd256;
			4'd9: v = 17'd128;
			4'd10: v = 17'd64;
			4'd11: v = 17'd32;
			4'd12: v = 17'd16;
			4'd13: v = 17'd8;
			4'd14: v = 17'd4;
			default: v = 17'd2;
		endcase
		return v;
	endfunction

	function automatic logic signed [17:0] wrap_ang(input logic signed [17:0] d);
		logic signed [17:0] r;
		r = d;
		if (d > ANG_PI) begin
			r = d - ANG_TWO_PI;
		end else if (d < -ANG_PI) begin
			r = d + ANG_TWO_PI;
		end
		return r;
	endfunction

endpackage

>>> design/swmk_cordic.sv
// swmk_cordic: iterative vectoring cordic, one micro-rotation per cycle
// depends on swmk_pkg for the arctan table
`timescale 1ns / 1ps
module swmk_cordic import swmk_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [17:0] cx,
	input  logic signed [17:0] cy,
	output logic               done,
	output logic signed [15:0] angle
);

	logic signed [35:0] x_q, y_q, x0, y0, xsh, ysh;
	logic signed [19:0] acc_q, acc0, acc_rnd;
	logic [3:0] step_q;
	logic busy_q, done_q;

	always_comb begin
		x0 = {{2{cx[17]}}, cx, 16'd0};
		y0 = {{2{cy[17]}}, cy, 16'd0};
		acc0 = '0;
		if (cx < 0) begin
			if (cy >= 0) begin
				x0 = {{2{cy[17]}}, cy, 16'd0};
				y0 = -{{2{cx[17]}}, cx, 16'd0};
				acc0 = CORDIC_HALF_PI;
			end else begin
				x0 = -{{2{cy[17]}}, cy, 16'd0};
				y0 = {{2{cx[17]}}, cx, 16'd0};
				acc0 = -CORDIC_HALF_PI;
			end
		end
		xsh = x_q >>> step_q;
		ysh = y_q >>> step_q;
		acc_rnd = (acc_q + 20'sd8) >>> 4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 4'd1;
			if (step_q == 4'(CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0;
			y_q <= y0;
			acc_q <= acc0;
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ysh;
				y_q <= y_q - xsh;
				acc_q <= acc_q + $signed({3'd0, atan_lut(step_q)});
			end else begin
				x_q <= x_q - ysh;
				y_q <= y_q + xsh;
				acc_q <= acc_q - $signed({3'd0, atan_lut(step_q)});
			end
		end
	end

	assign done = done_q;
	assign angle = acc_rnd[15:0];

endmodule

>>> design/swmk_sqrt.sv
// swmk_sqrt: digit-serial integer square root, two radicand bits per cycle
// depends on swmk_pkg for the step count
`timescale 1ns / 1ps
module swmk_sqrt import swmk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [49:0] radicand,
	output logic        done,
	output logic [24:0] root
);

	logic [49:0] data_q;
	logic [27:0] rem_q, rem_nx, trial;
	logic [24:0] root_q;
	logic [4:0] cnt_q;
	logic busy_q, done_q;

	always_comb begin
		rem_nx = {rem_q[25:0], data_q[49:48]};
		trial = {1'b0, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'(SQRT_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			data_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			data_q <= {data_q[47:0], 2'b00};
			if (rem_nx >= trial) begin
				rem_q <= rem_nx - trial;
				root_q <= {root_q[23:0], 1'b1};
			end else begin
				rem_q <= rem_nx;
				root_q <= {root_q[23:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> design/swerve_module_kinematics_top.sv
// swerve_module_kinematics_top: four-module swerve inverse kinematics, one beat in, one out
// path: disabled or lock mode goes straight to the output state; otherwise a rotation term,
// then per module the x and y squares, a square root in parallel with a 16-step cordic,
// a rate multiply and a finish step, then the output state loads the output register
// throughput: one item at a time; the next beat is taken once the result is registered
// reset: arst_n clears control state, idle counter, lock flag and restores register defaults
`timescale 1ns / 1ps
module swerve_module_kinematics_top import swmk_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] command_vx,
	input  logic signed [15:0] command_vy,
	input  logic signed [15:0] command_spin,
	input  logic signed [15:0] ramped_vx,
	input  logic signed [15:0] ramped_vy,
	input  logic signed [15:0] ramped_spin,
	input  logic signed [14:0] steer_angle_0,
	input  logic signed [14:0] steer_angle_1,
	input  logic signed [14:0] steer_angle_2,
	input  logic signed [14:0] steer_angle_3,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] steer_target_0,
	output logic signed [15:0] steer_target_1,
	output logic signed [15:0] steer_target_2,
	output logic signed [15:0] steer_target_3,
	output logic signed [17:0] wheel_speed_0,
	output logic signed [17:0] wheel_speed_1,
	output logic signed [17:0] wheel_speed_2,
	output logic signed [17:0] wheel_speed_3,
	output logic               locked
);

	state_t state_q, state_nx;

	logic mode_q;
	logic [15:0] delay_q, rot_q, iwr_q;
	logic [14:0] thr_q;
	logic [IDLE_W-1:0] idle_q, idle_nx;
	logic lock_q, lock_nx, do_lock, is_idle, accept;

	logic signed [15:0] vx_q, vy_q, sp_q;
	logic signed [14:0] cur_q [MODULES];
	logic signed [14:0] cur_in [MODULES];
	logic signed [16:0] r_q;
	logic signed [32:0] rot_prod;
	logic [1:0] idx_q;
	logic signed [17:0] mx, my;
	logic [33:0] sq_q;
	logic [40:0] prod_q;
	logic zero_vec;

	logic signed [15:0] tgt_q [MODULES];
	logic signed [17:0] spd_q [MODULES];
	logic lockres_q;
	logic signed [15:0] lock_tgt [MODULES];

	logic cor_start, cor_done, sq_start, sq_done;
	logic signed [15:0] cor_ang;
	logic [24:0] mag;

	logic signed [17:0] cur_e, ang_e, d, ang2, fin_d, tgt_full;
	logic [22:0] rnd;
	logic [17:0] sat;
	logic signed [17:0] spd_fin;
	logic neg;

	logic out_valid_q, locked_q;
	logic signed [15:0] ot_q [MODULES];
	logic signed [17:0] os_q [MODULES];

	assign cfg_ready = 1'b1;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			delay_q <= 16'd100;
			thr_q <= 15'd20;
			rot_q <= 16'd13107;
			iwr_q <= 16'd4267;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MODE: mode_q <= cfg_data[0];
				CFG_DELAY: delay_q <= cfg_data;
				CFG_THR: thr_q <= cfg_data[14:0];
				CFG_ROT: rot_q <= cfg_data;
				CFG_IWR: iwr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// idle detection and lock bookkeeping
	function automatic logic below(input logic signed [15:0] c, input logic [14:0] t);
		logic signed [16:0] a;
		a = (c < 0) ? -{c[15], c} : {c[15], c};
		return a < $signed({2'b00, t});
	endfunction

	always_comb begin
		is_idle = below(command_vx, thr_q) && below(command_vy, thr_q) &&
			below(command_spin, thr_q);
		idle_nx = idle_q;
		lock_nx = lock_q;
		if (is_idle) begin
			if (idle_q != {IDLE_W{1'b1}}) begin
				idle_nx = idle_q + 1'b1;
			end
			if (idle_nx > delay_q) begin
				lock_nx = 1'b1;
			end
		end else if (lock_q) begin
			idle_nx = '0;
			lock_nx = 1'b0;
		end
		do_lock = is_idle && lock_nx;
	end

	assign cur_in[0] = steer_angle_0;
	assign cur_in[1] = steer_angle_1;
	assign cur_in[2] = steer_angle_2;
	assign cur_in[3] = steer_angle_3;

	always_comb begin
		for (int i = 0; i < MODULES; i++) begin
			logic signed [17:0] c, aim, t;
			c = 18'(cur_in[i]);
			aim = (i % 2 == 0) ? -ANG_QUARTER_PI : ANG_QUARTER_PI;
			t = c + wrap_ang(aim - c);
			lock_tgt[i] = t[15:0];
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_nx = (mode_q && !do_lock) ? ST_ROT : ST_OUT;
			ST_ROT: state_nx = ST_SQX;
			ST_SQX: state_nx = ST_SQY;
			ST_SQY: state_nx = ST_START;
			ST_START: state_nx = ST_WAIT;
			ST_WAIT: if (cor_done && sq_done) state_nx = ST_MUL;
			ST_MUL: state_nx = ST_FIN;
			ST_FIN: state_nx = (idx_q == 2'(MODULES - 1)) ? ST_OUT : ST_SQX;
			ST_OUT: if (!out_valid_q || out_ready) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		cor_start = 1'b0;
		sq_start = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_START: begin
				cor_start = 1'b1;
				sq_start = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idle_q <= '0;
			lock_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				idx_q <= '0;
				if (mode_q) begin
					idle_q <= idle_nx;
					lock_q <= lock_nx;
				end
			end else if (state_q == ST_FIN) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// module vector components
	always_comb begin
		logic signed [17:0] vx, vy, r;
		vx = 18'(vx_q);
		vy = 18'(vy_q);
		r = 18'(r_q);
		case (idx_q)
			2'd0: begin mx = vx - r; my = vy + r; end
			2'd1: begin mx = vx + r; my = vy + r; end
			2'd2: begin mx = vx + r; my = vy - r; end
			default: begin mx = vx - r; my = vy - r; end
		endcase
		zero_vec = (mx == 0) && (my == 0);
		rot_prod = sp_q * $signed({1'b0, rot_q});
	end

	// finish: angle selection, reversal, short arc, rate saturation
	always_comb begin
		cur_e = 18'(cur_q[idx_q]);
		ang_e = zero_vec ? cur_e : 18'(cor_ang);
		d = wrap_ang(ang_e - cur_e);
		ang2 = ang_e;
		neg = 1'b0;
		if (d > ANG_HALF_PI) begin
			ang2 = cur_e + d - ANG_PI;
			neg = 1'b1;
		end else if (d < -ANG_HALF_PI) begin
			ang2 = cur_e + d + ANG_PI;
			neg = 1'b1;
		end
		fin_d = wrap_ang(ang2 - cur_e);
		tgt_full = cur_e + fin_d;
		rnd = 23'((prod_q + 41'd262144) >> 19);
		sat = (rnd > 23'(SPEED_MAX)) ? SPEED_MAX : rnd[17:0];
		if (zero_vec) begin
			sat = '0;
		end
		spd_fin = neg ? -$signed(sat) : $signed(sat);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vx_q <= ramped_vx;
			vy_q <= ramped_vy;
			sp_q <= ramped_spin;
			for (int i = 0; i < MODULES; i++) begin
				cur_q[i] <= cur_in[i];
				tgt_q[i] <= (mode_q && do_lock) ? lock_tgt[i] : '0;
				spd_q[i] <= '0;
			end
			lockres_q <= mode_q && do_lock;
		end
		unique case (state_q)
			ST_ROT: r_q <= 17'((rot_prod + 33'sd32768) >>> 16);
			ST_SQX: sq_q <= 34'(mx * mx);
			ST_SQY: sq_q <= sq_q + 34'(my * my);
			ST_MUL: prod_q <= mag * iwr_q;
			ST_FIN: begin
				tgt_q[idx_q] <= tgt_full[15:0];
				spd_q[idx_q] <= spd_fin;
			end
			default: ;
		endcase
	end

	swmk_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cor_start),
		.cx(mx),
		.cy(my),
		.done(cor_done),
		.angle(cor_ang)
	);

	swmk_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sq_start),
		.radicand({sq_q, 16'd0}),
		.done(sq_done),
		.root(mag)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			for (int i = 0; i < MODULES; i++) begin
				ot_q[i] <= tgt_q[i];
				os_q[i] <= spd_q[i];
			end
			locked_q <= lockres_q;
		end
	end

	assign out_valid = out_valid_q;
	assign steer_target_0 = ot_q[0];
	assign steer_target_1 = ot_q[1];
	assign steer_target_2 = ot_q[2];
	assign steer_target_3 = ot_q[3];
	assign wheel_speed_0 = os_q[0];
	assign wheel_speed_1 = os_q[1];
	assign wheel_speed_2 = os_q[2];
	assign wheel_speed_3 = os_q[3];
	assign locked = locked_q;

`ifndef ASSERT_OFF
	a_lock_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && locked) |-> (wheel_speed_0 == 0 && wheel_speed_1 == 0 &&
		wheel_speed_2 == 0 && wheel_speed_3 == 0))
		else $error("locked beat with nonzero wheel speed");
	a_idle_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(idle_q != $past(idle_q)) |-> (idle_q == $past(idle_q) + 1'b1 || idle_q == 0))
		else $error("idle counter jumped");
	a_disabled_short: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !mode_q) |=> (state_q == ST_OUT))
		else $error("disabled beat took the kinematics path");
	a_start_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (cor_done && sq_done))
		else $error("rate multiply before root and angle finished");
`endif

endmodule

>>> dv/swerve_module_kinematics_top_test.sv
// swerve_module_kinematics_top_test: self-checking bench for the swerve kinematics block
// drives command beats and register writes, predicts each result in-bench; needs swmk_pkg
`timescale 1ns / 1ps
module swerve_module_kinematics_top_test;
	import swmk_pkg::*;

	typedef struct {
		logic signed [15:0] cmd_vx, cmd_vy, cmd_spin;
		logic signed [15:0] ramp_vx, ramp_vy, ramp_spin;
		logic signed [14:0] angle [4];
	} command_t;

	typedef struct {
		logic signed [15:0] target [4];
		logic signed [17:0] speed [4];
		logic lock;
	} wheel_set_t;

	localparam longint K_PI = 12868;
	localparam longint K_HALF = 6434;
	localparam longint K_QUARTER = 3217;
	localparam longint K_TWO_PI = 25736;
	localparam longint K_CORDIC_HALF = 102944;
	localparam longint K_RATE_MAX = 131071;
	localparam longint K_IDLE_MAX = 65535;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam longint ARCTAN [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2};

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [15:0] command_vx = '0, command_vy = '0, command_spin = '0;
	logic signed [15:0] ramped_vx = '0, ramped_vy = '0, ramped_spin = '0;
	logic signed [14:0] steer_angle_0 = '0, steer_angle_1 = '0;
	logic signed [14:0] steer_angle_2 = '0, steer_angle_3 = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [15:0] steer_target_0, steer_target_1, steer_target_2, steer_target_3;
	logic signed [17:0] wheel_speed_0, wheel_speed_1, wheel_speed_2, wheel_speed_3;
	logic locked;

	swerve_module_kinematics_top DUT (.*);

	// predictor copy of registers and state
	longint mode_q = 0, delay_q = 100, thr_q = 20, rot_q = 13107, iwr_q = 4267;
	longint idle_cnt = 0;
	bit lock_on = 0;

	command_t pending_cmds [$];
	wheel_set_t expected_sets [$];
	int fail_count = 0;
	bit in_fire = 0;
	int burst_left = 0, gap_left = 0;
	int stall_cycles = 0;
	int watchdog = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic longint wrap(longint d);
		while (d > K_PI) d -= K_TWO_PI;
		while (d < -K_PI) d += K_TWO_PI;
		return d;
	endfunction

	function automatic longint root_floor(longint unsigned n);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint heading(longint cy, longint cx);
		longint x = cx * 65536;
		longint y = cy * 65536;
		longint acc = 0;
		longint t, xs, ys;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; acc = K_CORDIC_HALF;
			end else begin
				x = -y; y = t; acc = -K_CORDIC_HALF;
			end
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; acc += ARCTAN[i];
			end else begin
				x -= ys; y += xs; acc -= ARCTAN[i];
			end
		end
		return (acc + 8) >>> 4;
	endfunction

	function automatic longint absv(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic wheel_set_t predict_wheels(command_t c);
		wheel_set_t w;
		longint cur [4];
		longint mx [4], my [4];
		longint r, ang, d, s, mag, prod;
		bit idle, lock_now;
		lock_now = 0;
		w.lock = 0;
		for (int i = 0; i < 4; i++) begin
			cur[i] = c.angle[i];
			w.target[i] = '0;
			w.speed[i] = '0;
		end
		if (mode_q != 0) begin
			idle = absv(c.cmd_vx) < thr_q && absv(c.cmd_vy) < thr_q && absv(c.cmd_spin) < thr_q;
			if (idle) begin
				if (idle_cnt < K_IDLE_MAX) idle_cnt++;
				if (idle_cnt > delay_q) lock_on = 1;
				lock_now = lock_on;
			end else if (lock_on) begin
				lock_on = 0;
				idle_cnt = 0;
			end
			if (lock_now) begin
				for (int i = 0; i < 4; i++) begin
					ang = (i % 2 == 0) ? -K_QUARTER : K_QUARTER;
					w.target[i] = 16'(cur[i] + wrap(ang - cur[i]));
				end
				w.lock = 1;
			end else begin
				r = (longint'(c.ramp_spin) * rot_q + 32768) >>> 16;
				mx[0] = c.ramp_vx - r; mx[3] = c.ramp_vx - r;
				mx[1] = c.ramp_vx + r; mx[2] = c.ramp_vx + r;
				my[0] = c.ramp_vy + r; my[1] = c.ramp_vy + r;
				my[2] = c.ramp_vy - r; my[3] = c.ramp_vy - r;
				for (int i = 0; i < 4; i++) begin
					mag = root_floor((mx[i] * mx[i] + my[i] * my[i]) << 16);
					prod = (mag * iwr_q + (64'd1 << 18)) >>> 19;
					s = prod > K_RATE_MAX ? K_RATE_MAX : prod;
					if (mx[i] == 0 && my[i] == 0) begin
						ang = cur[i];
						s = 0;
					end else begin
						ang = heading(my[i], mx[i]);
					end
					d = wrap(ang - cur[i]);
					if (d > K_HALF) begin
						ang = cur[i] + d - K_PI; s = -s;
					end else if (d < -K_HALF) begin
						ang = cur[i] + d + K_PI; s = -s;
					end
					w.target[i] = 16'(cur[i] + wrap(ang - cur[i]));
					w.speed[i] = 18'(s);
				end
			end
		end
		return w;
	endfunction

	// sender: bursts with random gaps
	always @(negedge clk) begin
		command_t c;
		if (arst_n && !(in_valid && !in_fire)) begin
			if (gap_left > 0) begin
				in_valid <= 0;
				gap_left--;
			end else if (pending_cmds.size() > 0) begin
				c = pending_cmds.pop_front();
				in_valid <= 1;
				command_vx <= c.cmd_vx; command_vy <= c.cmd_vy; command_spin <= c.cmd_spin;
				ramped_vx <= c.ramp_vx; ramped_vy <= c.ramp_vy; ramped_spin <= c.ramp_spin;
				steer_angle_0 <= c.angle[0]; steer_angle_1 <= c.angle[1];
				steer_angle_2 <= c.angle[2]; steer_angle_3 <= c.angle[3];
				if (burst_left > 0) burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 20);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 200);
				end
			end else begin
				in_valid <= 0;
			end
		end
	end

	// receiver: own stall pattern plus a long hold-off now and then
	always @(negedge clk) begin
		stall_cycles++;
		if (stall_cycles % 60000 == 3000) gap_left = 0;
		if (stall_cycles % 60000 >= 3000 && stall_cycles % 60000 < 4500) begin
			out_ready <= 0;
		end else begin
			case ((stall_cycles / 512) % 3)
				0: out_ready <= 1;
				1: out_ready <= ($urandom_range(0, 1) == 0);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// monitor: predict on each input beat, check each output beat
	always @(posedge clk) begin
		wheel_set_t got, want;
		command_t c;
		in_fire <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			c.cmd_vx = command_vx; c.cmd_vy = command_vy; c.cmd_spin = command_spin;
			c.ramp_vx = ramped_vx; c.ramp_vy = ramped_vy; c.ramp_spin = ramped_spin;
			c.angle[0] = steer_angle_0; c.angle[1] = steer_angle_1;
			c.angle[2] = steer_angle_2; c.angle[3] = steer_angle_3;
			expected_sets.push_back(predict_wheels(c));
		end
		if (out_valid && out_ready) begin
			got.target[0] = steer_target_0; got.target[1] = steer_target_1;
			got.target[2] = steer_target_2; got.target[3] = steer_target_3;
			got.speed[0] = wheel_speed_0; got.speed[1] = wheel_speed_1;
			got.speed[2] = wheel_speed_2; got.speed[3] = wheel_speed_3;
			got.lock = locked;
			if (expected_sets.size() == 0) begin
				$error("output beat with nothing expected");
				fail_count++;
			end else begin
				want = expected_sets.pop_front();
				for (int i = 0; i < 4; i++) begin
					if (got.target[i] !== want.target[i]) begin
						$error("steer_target_%0d expected %0d got %0d", i, want.target[i],
							got.target[i]);
						fail_count++;
					end
					if (got.speed[i] !== want.speed[i]) begin
						$error("wheel_speed_%0d expected %0d got %0d", i, want.speed[i],
							got.speed[i]);
						fail_count++;
					end
				end
				if (got.lock !== want.lock) begin
					$error("locked expected %0d got %0d", want.lock, got.lock);
					fail_count++;
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			watchdog <= 0;
		else
			watchdog <= watchdog + 1;
		if (watchdog >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_MODE: mode_q = value[0];
			CFG_DELAY: delay_q = value;
			CFG_THR: thr_q = value[14:0];
			CFG_ROT: rot_q = value;
			default: iwr_q = value;
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic set_all(int m, int dl, int th, int rt, int iw);
		write_reg(CFG_MODE, 16'(m));
		write_reg(CFG_DELAY, 16'(dl));
		write_reg(CFG_THR, 16'(th));
		write_reg(CFG_ROT, 16'(rt));
		write_reg(CFG_IWR, 16'(iw));
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || in_valid || expected_sets.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic command_t make_cmd(int cvx, int cvy, int csp, int rvx, int rvy, int rsp,
		int a0, int a1, int a2, int a3);
		command_t c;
		c.cmd_vx = 16'(cvx); c.cmd_vy = 16'(cvy); c.cmd_spin = 16'(csp);
		c.ramp_vx = 16'(rvx); c.ramp_vy = 16'(rvy); c.ramp_spin = 16'(rsp);
		c.angle[0] = 15'(a0); c.angle[1] = 15'(a1); c.angle[2] = 15'(a2); c.angle[3] = 15'(a3);
		return c;
	endfunction

	function automatic int rand_angle();
		case ($urandom_range(0, 7))
			0: return 12868;
			1: return -12868;
			default: return $urandom_range(0, 25736) - 12868;
		endcase
	endfunction

	function automatic int small_cmd();
		int v;
		if (thr_q == 0) return 0;
		v = $urandom_range(0, thr_q - 1);
		return $urandom_range(0, 1) ? v : -v;
	endfunction

	function automatic int wide();
		return $urandom_range(0, 65535) - 32768;
	endfunction

	function automatic int modest();
		return $urandom_range(0, 8191) - 4096;
	endfunction

	function automatic command_t random_cmd();
		int k;
		k = $urandom_range(0, 9);
		if (k <= 3)
			return make_cmd(small_cmd(), small_cmd(), small_cmd(), modest(), modest(), modest(),
				rand_angle(), rand_angle(), rand_angle(), rand_angle());
		else if (k <= 6)
			return make_cmd(modest(), modest(), modest(), modest(), modest(), modest(),
				rand_angle(), rand_angle(), rand_angle(), rand_angle());
		else if (k <= 8)
			return make_cmd(wide(), wide(), wide(), wide(), wide(), wide(),
				rand_angle(), rand_angle(), rand_angle(), rand_angle());
		return make_cmd(32767, 0, 0, 0, 0, 0, rand_angle(), rand_angle(), rand_angle(),
			rand_angle());
	endfunction

	initial begin
		int settings [10][5];
		settings = '{'{1, 3, 300, 13107, 4267}, '{1, 0, 32767, 65535, 65535},
			'{1, 65535, 0, 0, 1}, '{1, 10, 2000, 20000, 256},
			'{1, 1, 500, 65535, 1}, '{1, 5, 100, 0, 65535},
			'{0, 2, 1000, 13107, 4267}, '{1, 20, 1000, 30000, 9000},
			'{1, 0, 10, 5000, 40000}, '{1, 4, 4000, 13107, 4267}};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// disabled mode with defaults
		set_all(0, 100, 20, 13107, 4267);
		pending_cmds.push_back(make_cmd(1000, 1000, 1000, 1000, 2000, 300, 5, 6, 7, 8));
		pending_cmds.push_back(make_cmd(0, 0, 0, 0, 0, 0, 12868, -12868, 0, 1));
		wait_drained();

		set_all(1, 2, 300, 13107, 4267);
		pending_cmds.push_back(make_cmd(32767, 32767, 32767, 32767, 32767, 32767,
			12868, 12868, 12868, 12868));
		pending_cmds.push_back(make_cmd(-32768, -32768, -32768, -32768, -32768, -32768,
			-12868, -12868, -12868, -12868));
		pending_cmds.push_back(make_cmd(2000, 0, 0, 0, 0, 0, 100, -100, 0, 0));
		pending_cmds.push_back(make_cmd(0, 0, 2000, 0, 0, 4000, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(2000, 0, 0, -4000, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(2000, 0, 0, 0, -4000, 0, 6434, -6434, 12868, -12868));
		pending_cmds.push_back(make_cmd(2000, 0, 0, -4000, 1, 0, 12868, -12868, 0, 0));
		// idle run into lock, held, then released
		for (int i = 0; i < 5; i++)
			pending_cmds.push_back(make_cmd(-299, 299, 0, 3000, 3000, 100,
				12868, -12868, 4000, -4000));
		pending_cmds.push_back(make_cmd(300, 0, 0, 3000, -3000, -100, 1, 2, 3, 4));
		pending_cmds.push_back(make_cmd(0, 0, 0, 3000, -3000, -100, 1, 2, 3, 4));
		pending_cmds.push_back(make_cmd(0, 0, -300, 1, 1, 0, 1, 2, 3, 4));
		wait_drained();

		for (int p = 0; p < 10; p++) begin
			set_all(settings[p][0], settings[p][1], settings[p][2], settings[p][3],
				settings[p][4]);
			for (int i = 0; i < 155; i++) pending_cmds.push_back(random_cmd());
			wait_drained();
		end

		repeat (200) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
